// ----- rtl/u16u8_pkg.sv -----
// Package for the UTF-16 to UTF-8 transcoder: mode codes, byte constants,
// queue sizing and the job descriptor passed from front to back.
// No dependencies.
package u16u8_pkg;

    // Mode register codes (value 3 behaves as big endian)
    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_LE    = 2'd1;
    localparam logic [1:0] MODE_BE    = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_LE;

    // ASCII filter
    localparam logic [7:0] ASCII_LOW  = 8'd32;
    localparam logic [7:0] ASCII_HIGH = 8'd126;
    localparam logic [7:0] ASCII_SUB  = 8'h3F;

    // Surrogate tags (upper six bits of a code unit)
    localparam logic [5:0] TAG_HIGH = 6'b110110;
    localparam logic [5:0] TAG_LOW  = 6'b110111;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Replacement character U+2370 as UTF-8
    localparam logic [7:0] REP_B0 = 8'hE2;
    localparam logic [7:0] REP_B1 = 8'h8D;
    localparam logic [7:0] REP_B2 = 8'hB0;

    // Job queue sizing
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // What the back end emits after the optional leading replacement
    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_REP,
        BODY_CP
    } t_body;

    typedef struct packed {
        logic        pre_rep;
        t_body       body;
        logic [20:0] cp;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

    typedef enum logic {
        PART_PRE,
        PART_BODY
    } t_part;

endpackage

// ----- rtl/u16u8_in_if.sv -----
// Input channel: raw data bytes with end-of-data flag.
// No dependencies.
interface u16u8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;

    modport source (output valid, output in_byte, output end_of_data, input ready);
    modport sink   (input valid, input in_byte, input end_of_data, output ready);
endinterface

// ----- rtl/u16u8_out_if.sv -----
// Output channel: UTF-8 bytes with run and replacement flags.
// No dependencies.
interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       is_replacement;

    modport source (output valid, output out_byte, output last_of_run,
                    output is_replacement, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input is_replacement, output ready);
endinterface

// ----- rtl/u16u8_front.sv -----
// Front end: accepts raw bytes, pairs them into code units, tracks surrogates
// and turns input bytes into job descriptors. Uses u16u8_pkg, u16u8_in_if.
module u16u8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u16u8_in_if.sink          i_in,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_q_full,
    output logic              o_push,
    output u16u8_pkg::t_job   o_job
);
    import u16u8_pkg::*;

    logic [1:0]  r_mode,    n_mode;
    logic [7:0]  r_held,    n_held;
    logic        r_phase,   n_phase;
    logic [9:0]  r_pending, n_pending;
    logic        r_have,    n_have;

    logic        accept;
    logic [15:0] unit;
    logic        is_hi, is_lo, do_fresh;
    logic [20:0] cp_pair;
    t_job        job;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // code unit assembly and surrogate decode
    assign unit    = (r_mode != MODE_LE) ? {r_held, i_in.in_byte} : {i_in.in_byte, r_held};
    assign is_hi   = (unit[15:10] == TAG_HIGH);
    assign is_lo   = (unit[15:10] == TAG_LOW);
    assign cp_pair = SUPP_BASE + {1'b0, r_pending, unit[9:0]};

    // classification and next state
    always_comb begin
        n_mode    = r_mode;
        n_held    = r_held;
        n_phase   = r_phase;
        n_pending = r_pending;
        n_have    = r_have;
        do_fresh  = 1'b0;
        job.pre_rep = 1'b0;
        job.body    = BODY_NONE;
        job.cp      = '0;

        if (r_mode == MODE_ASCII) begin
            job.body = BODY_CP;
            job.cp   = (i_in.in_byte < ASCII_LOW || i_in.in_byte > ASCII_HIGH) ?
                       {13'd0, ASCII_SUB} : {13'd0, i_in.in_byte};
        end else if (!r_phase) begin
            if (i_in.end_of_data) begin
                job.body = BODY_REP;
                n_have   = 1'b0;
            end else begin
                n_held  = i_in.in_byte;
                n_phase = 1'b1;
            end
        end else begin
            n_phase  = 1'b0;
            do_fresh = 1'b1;
            if (r_have) begin
                n_have = 1'b0;
                if (is_lo) begin
                    job.body = BODY_CP;
                    job.cp   = cp_pair;
                    do_fresh = 1'b0;
                end else begin
                    job.pre_rep = 1'b1;
                end
            end
            // unit handled on its own
            if (do_fresh) begin
                if (is_hi) begin
                    if (i_in.end_of_data) begin
                        job.body = BODY_REP;
                    end else begin
                        n_pending = unit[9:0];
                        n_have    = 1'b1;
                    end
                end else if (is_lo) begin
                    job.body = BODY_REP;
                end else begin
                    job.body = BODY_CP;
                    job.cp   = {5'd0, unit};
                end
            end
            if (i_in.end_of_data) begin
                n_have = 1'b0;
            end
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.pre_rep || job.body != BODY_NONE);

    // state registers; a mode write restarts the stream
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RESET;
            r_held    <= '0;
            r_phase   <= 1'b0;
            r_pending <= '0;
            r_have    <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode    <= i_cfg_wdata;
            r_held    <= '0;
            r_phase   <= 1'b0;
            r_pending <= '0;
            r_have    <= 1'b0;
        end else if (accept) begin
            r_mode    <= n_mode;
            r_held    <= n_held;
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_have    <= n_have;
        end
    end

endmodule

// ----- rtl/u16u8_queue.sv -----
// Short job queue between front and back ends.
// Uses u16u8_pkg.
module u16u8_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  u16u8_pkg::t_job       i_job,
    input  logic                  i_pop,
    output u16u8_pkg::t_job       o_head,
    output u16u8_pkg::t_q_status  o_status
);
    import u16u8_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/u16u8_back.sv -----
// Back end: expands one job at a time into UTF-8 bytes, one per cycle while the
// output is not stalled, into an output register. Uses u16u8_pkg, u16u8_out_if.
module u16u8_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  u16u8_pkg::t_job          i_job,
    output logic                     o_pop,
    u16u8_out_if.source              o_out,
    output u16u8_pkg::t_back_status  o_status
);
    import u16u8_pkg::*;

    t_job       r_job,  n_job;
    logic       r_busy, n_busy;
    t_part      r_part, n_part;
    logic [1:0] r_idx,  n_idx;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte,  n_out_byte;
    logic       r_out_last,  n_out_last;
    logic       r_out_rep,   n_out_rep;

    logic       adv, load, sec_last, job_done, cur_rep;
    logic [7:0] cur_byte;
    logic [1:0] cp_last;

    function automatic logic [7:0] rep_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = REP_B0;
            2'd1:    b = REP_B1;
            default: b = REP_B2;
        endcase
        return b;
    endfunction

    // UTF-8 byte idx of a code point whose encoding ends at index last
    function automatic logic [7:0] cp_byte(input logic [20:0] cp, input logic [1:0] last,
                                           input logic [1:0] idx);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (last)
            2'd0: b = {1'b0, cp[6:0]};
            2'd1: if (idx == 2'd0) b = {3'b110, cp[10:6]};
            2'd2: begin
                if (idx == 2'd0)      b = {4'b1110, cp[15:12]};
                else if (idx == 2'd1) b = {2'b10, cp[11:6]};
            end
            default: begin
                if (idx == 2'd0)      b = {5'b11110, cp[20:18]};
                else if (idx == 2'd1) b = {2'b10, cp[17:12]};
                else if (idx == 2'd2) b = {2'b10, cp[11:6]};
            end
        endcase
        return b;
    endfunction

    // encoded length of the current code point
    always_comb begin
        if (r_job.cp < 21'h80)         cp_last = 2'd0;
        else if (r_job.cp < 21'h800)   cp_last = 2'd1;
        else if (r_job.cp < 21'h10000) cp_last = 2'd2;
        else                           cp_last = 2'd3;
    end

    assign adv = r_busy && (!r_out_valid || o_out.ready);

    // current byte selection
    always_comb begin
        if (r_part == PART_PRE) begin
            cur_byte = rep_byte(r_idx);
            cur_rep  = 1'b1;
            sec_last = (r_idx == 2'd2);
            job_done = sec_last && (r_job.body == BODY_NONE);
        end else if (r_job.body == BODY_REP) begin
            cur_byte = rep_byte(r_idx);
            cur_rep  = 1'b1;
            sec_last = (r_idx == 2'd2);
            job_done = sec_last;
        end else begin
            cur_byte = cp_byte(r_job.cp, cp_last, r_idx);
            cur_rep  = 1'b0;
            sec_last = (r_idx == cp_last);
            job_done = sec_last;
        end
    end

    assign load  = !r_busy || (adv && job_done);
    assign o_pop = load && !i_q_empty;

    // sequencer and output register
    always_comb begin
        n_job       = r_job;
        n_busy      = r_busy;
        n_part      = r_part;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_rep   = r_out_rep;

        if (adv) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_last  = job_done;
            n_out_rep   = cur_rep;
            n_idx       = sec_last ? 2'd0 : r_idx + 2'd1;
            if (sec_last && r_part == PART_PRE) begin
                n_part = PART_BODY;
            end
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (load) begin
            if (!i_q_empty) begin
                n_job  = i_job;
                n_busy = 1'b1;
                n_part = i_job.pre_rep ? PART_PRE : PART_BODY;
                n_idx  = 2'd0;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_part      <= PART_PRE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_part      <= n_part;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_rep  <= n_out_rep;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.last_of_run    = r_out_last;
    assign o_out.is_replacement = r_out_rep;
    assign o_status.busy        = r_busy;

endmodule

// ----- rtl/utf16_to_utf8_transcoder.sv -----
// UTF-16 / ASCII to UTF-8 transcoder top level.
// Throughput: one input byte per cycle while the 4-entry job queue has room;
// one output byte per cycle from the back-end expander while the output is not
// stalled; a job yields 1 to 4 bytes, or up to 6 with a leading replacement.
// Reset: mode = UTF-16 LE, surrogate state and queue cleared, output empty.
module utf16_to_utf8_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_out_if.source o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata
);
    import u16u8_pkg::*;

    logic         push, pop;
    t_job         push_job, head_job;
    t_q_status    q_stat;
    t_back_status back_stat;

    u16u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_job       (push_job)
    );

    u16u8_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_stat)
    );

    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_out     (o_out),
        .o_status  (back_stat)
    );

`ifndef SYNTHESIS
    // a replacement never ends on its lead byte
    a_rep_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.is_replacement && o_out.out_byte == REP_B0
        |-> !o_out.last_of_run)
        else $error("replacement lead byte flagged as last of run");

    // no bubble inside a run
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_run |=> o_out.valid)
        else $error("gap inside an output run");

    // fully idle pipeline shows no output in the next cycle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.empty && !back_stat.busy && !o_out.valid |=> !o_out.valid)
        else $error("output appeared from an idle pipeline");
`endif

endmodule
